>>> design/lvc_pkg.sv
// Shared types and constants for the link visibility check pipeline.
`default_nettype none

package lvc_pkg;

   // Wide multiplier organisation: 32-bit digits, a registered adder tree of
   // five levels (up to 32 partial products), one stage for magnitudes, one
   // for the partial products and one for the sign.
   localparam int MUL_CHUNK       = 32;
   localparam int MUL_TREE_LEVELS = 5;
   localparam int MUL_MAX_PP      = 32;
   localparam int MUL_LAT         = MUL_TREE_LEVELS + 3;

   localparam logic [31:0]        MAX_RANGE_RST    = 32'd1280000;
   localparam logic signed [15:0] SIN_MIN_RST      = 16'sd0;
   localparam logic [31:0]        EARTH_RADIUS_RST = 32'd1630976;

   typedef enum logic [1:0] {
      CSR_MAX_RANGE    = 2'd0,
      CSR_SIN_MIN_ELEV = 2'd1,
      CSR_EARTH_RADIUS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic               first_is_satellite;
      logic               second_is_satellite;
   } req_type;

   typedef struct packed {
      logic        linked;
      logic [31:0] link_distance;
   } rsp_type;

   // Decision flags worked out once the dot products are known.
   typedef struct packed {
      logic first_sat;
      logic second_sat;
      logic range_ok;
      logic ad_neg;
      logic far_b;
      logic near_a;
      logic near_b;
      logic g_zero;
      logic dsq_zero;
      logic v_neg;
   } ctl_type;

endpackage

`default_nettype wire

>>> design/lvc_mul.sv
// Pipelined signed multiplier built from 32 by 32 bit partial products.
`default_nettype none

module lvc_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);
   import lvc_pkg::*;

   localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int UW = (NA + NB) * MUL_CHUNK;
   localparam int PW = AW + BW;

   logic [AW-1:0]           a_mag;
   logic [BW-1:0]           b_mag;
   logic [NA*MUL_CHUNK-1:0] am_ff;
   logic [NB*MUL_CHUNK-1:0] bm_ff;
   logic [MUL_LAT-2:0]      neg_ff;
   logic [UW-1:0]           tree_ff [0:MUL_TREE_LEVELS][0:MUL_MAX_PP-1];
   logic signed [PW-1:0]    p_ff;

   // The magnitude of the most negative value still fits the unsigned width.
   assign a_mag = a[AW-1] ? AW'(~a + 1'b1) : a;
   assign b_mag = b[BW-1] ? BW'(~b + 1'b1) : b;

   always_ff @(posedge clock) begin
      am_ff  <= (NA*MUL_CHUNK)'(a_mag);
      bm_ff  <= (NB*MUL_CHUNK)'(b_mag);
      neg_ff <= {neg_ff[MUL_LAT-3:0], a[AW-1] ^ b[BW-1]};

      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            tree_ff[0][i*NB+j] <=
               UW'((2*MUL_CHUNK)'(am_ff[i*MUL_CHUNK +: MUL_CHUNK]) *
                   (2*MUL_CHUNK)'(bm_ff[j*MUL_CHUNK +: MUL_CHUNK])) << (MUL_CHUNK*(i+j));
         end
      end
      for (int k = NA*NB; k < MUL_MAX_PP; k++) begin
         tree_ff[0][k] <= '0;
      end

      for (int l = 1; l <= MUL_TREE_LEVELS; l++) begin
         for (int k = 0; k < (MUL_MAX_PP >> l); k++) begin
            tree_ff[l][k] <= tree_ff[l-1][2*k] + tree_ff[l-1][2*k+1];
         end
         for (int k = (MUL_MAX_PP >> l); k < MUL_MAX_PP; k++) begin
            tree_ff[l][k] <= '0;
         end
      end

      p_ff <= neg_ff[MUL_LAT-2] ? PW'(-tree_ff[MUL_TREE_LEVELS][0])
                                : PW'(tree_ff[MUL_TREE_LEVELS][0]);
   end

   assign p = p_ff;

endmodule

`default_nettype wire

>>> design/link_visibility_check_top.sv
// Top level of the line-of-sight link visibility check.
//
//  channel   | handshake                        | beat
//  ----------+----------------------------------+-------------------------------
//  request   | start, busy                      | req_data: two positions, flags
//  response  | rsp_strobe (one cycle, no stall) | rsp_data: linked, distance
//  registers | csr_valid, csr_ready             | csr_index, csr_wdata
//
// One node pair is taken every cycle; busy is only high during reset.
// The square root, one result bit per stage, is the longest path from a
// request beat to its result.
// The wide products run through eight-stage multipliers, three times in series.
// Reset is synchronous, clears the valid pipeline and presets the registers.
// The pipeline never stalls; the receiver must always take a response.
`default_nettype none

module link_visibility_check_top #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lvc_pkg::req_type    req_data,
   output logic                rsp_strobe,
   output lvc_pkg::rsp_type    rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import lvc_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int DW     = CW + 1;
   localparam int SW     = 2*CW + 4;
   localparam int R      = CW + 1;
   localparam int M1_OUT = 1 + MUL_LAT;
   localparam int SUM    = M1_OUT + 1;
   localparam int M2_OUT = SUM + MUL_LAT;
   localparam int M3_OUT = M2_OUT + MUL_LAT;
   localparam int DEC    = M3_OUT + 1;
   localparam int SQ_END = SUM + 1 + R;
   localparam int LAST   = SQ_END + 1;
   localparam int CTL_D  = M3_OUT - (SUM + 1);
   localparam int YD     = M3_OUT - M2_OUT - 1;
   localparam int FD     = M3_OUT - M2_OUT - 2;
   localparam int K      = SQ_END - DEC;

   // Configuration registers.
   logic [31:0]        max_range_ff;
   logic signed [15:0] sin_min_ff;
   logic [31:0]        earth_radius_ff;

   logic [LAST:0] vld_ff;
   logic [1:0]    satd_ff [0:SUM];

   logic signed [CW-1:0] in_a [0:2];
   logic signed [CW-1:0] in_b [0:2];
   logic signed [CW-1:0] a0_ff [0:2];
   logic signed [CW-1:0] b0_ff [0:2];
   logic signed [DW-1:0] a1_ff [0:2];
   logic signed [DW-1:0] b1_ff [0:2];
   logic signed [DW-1:0] d1_ff [0:2];

   logic signed [2*DW-1:0] dd_p [0:2];
   logic signed [2*DW-1:0] aa_p [0:2];
   logic signed [2*DW-1:0] bb_p [0:2];
   logic signed [2*DW-1:0] ad_p [0:2];
   logic signed [2*DW-1:0] bd_p [0:2];
   logic signed [65:0]     re2_p;
   logic signed [65:0]     mr2_p;

   logic signed [SW-1:0] dsq10_ff, aa10_ff, bb10_ff, ad10_ff, bd10_ff;
   logic signed [65:0]   re2_10_ff, mr2_10_ff;
   logic                 g_first;
   logic signed [SW-1:0] gsel, vsel;

   logic signed [2*SW-1:0]    x_p, y_p;
   logic signed [66+SW-1:0]   z_p;
   logic signed [31:0]        ss_p;
   logic signed [32+2*SW-1:0] t_p;

   logic signed [2*SW-1:0]  lhs_ff;
   logic signed [66+SW-1:0] z19_ff;
   logic                    far_ff [0:FD];
   logic signed [2*SW-1:0]  yd_ff  [0:YD];
   ctl_type                 ctl_in;
   ctl_type                 ctl_ff [0:CTL_D];
   ctl_type                 c;
   logic signed [2*SW+29:0] l2;
   logic                    ok_in;
   logic                    ok_ff [0:K];

   logic [2*R-1:0] sq_x_ff   [0:R-1];
   logic [R+1:0]   sq_rem_ff [0:R-1];
   logic [R-1:0]   sq_q_ff   [0:R];

   logic [R+31:0] root_w;
   logic [31:0]   dist_sat;
   rsp_type       rsp_ff;

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff    <= MAX_RANGE_RST;
         sin_min_ff      <= SIN_MIN_RST;
         earth_radius_ff <= EARTH_RADIUS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_RANGE:    max_range_ff    <= csr_wdata;
            CSR_SIN_MIN_ELEV: sin_min_ff      <= csr_wdata[15:0];
            CSR_EARTH_RADIUS: earth_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAST-1:0], start && !busy};
      end
   end

   // Coordinates keep their low COORD_WIDTH bits, or are sign extended.
   if (CW <= 32) begin : g_narrow
      assign in_a[0] = req_data.first_x[CW-1:0];
      assign in_a[1] = req_data.first_y[CW-1:0];
      assign in_a[2] = req_data.first_z[CW-1:0];
      assign in_b[0] = req_data.second_x[CW-1:0];
      assign in_b[1] = req_data.second_y[CW-1:0];
      assign in_b[2] = req_data.second_z[CW-1:0];
   end else begin : g_wide
      assign in_a[0] = CW'(req_data.first_x);
      assign in_a[1] = CW'(req_data.first_y);
      assign in_a[2] = CW'(req_data.first_z);
      assign in_b[0] = CW'(req_data.second_x);
      assign in_b[1] = CW'(req_data.second_y);
      assign in_b[2] = CW'(req_data.second_z);
   end

   always_ff @(posedge clock) begin
      satd_ff[0] <= {req_data.first_is_satellite, req_data.second_is_satellite};
      for (int i = 1; i <= SUM; i++) begin
         satd_ff[i] <= satd_ff[i-1];
      end
      for (int k = 0; k < 3; k++) begin
         a0_ff[k] <= in_a[k];
         b0_ff[k] <= in_b[k];
         a1_ff[k] <= DW'(a0_ff[k]);
         b1_ff[k] <= DW'(b0_ff[k]);
         d1_ff[k] <= DW'(b0_ff[k]) - DW'(a0_ff[k]);
      end
   end

   // Per-axis products for the five dot products.
   for (genvar k = 0; k < 3; k++) begin : g_axis
      lvc_mul #(.AW(DW), .BW(DW)) u_dd (.clock(clock), .a(d1_ff[k]), .b(d1_ff[k]), .p(dd_p[k]));
      lvc_mul #(.AW(DW), .BW(DW)) u_aa (.clock(clock), .a(a1_ff[k]), .b(a1_ff[k]), .p(aa_p[k]));
      lvc_mul #(.AW(DW), .BW(DW)) u_bb (.clock(clock), .a(b1_ff[k]), .b(b1_ff[k]), .p(bb_p[k]));
      lvc_mul #(.AW(DW), .BW(DW)) u_ad (.clock(clock), .a(a1_ff[k]), .b(d1_ff[k]), .p(ad_p[k]));
      lvc_mul #(.AW(DW), .BW(DW)) u_bd (.clock(clock), .a(b1_ff[k]), .b(d1_ff[k]), .p(bd_p[k]));
   end

   lvc_mul #(.AW(33), .BW(33)) u_re2 (
      .clock(clock),
      .a($signed({1'b0, earth_radius_ff})),
      .b($signed({1'b0, earth_radius_ff})),
      .p(re2_p)
   );
   lvc_mul #(.AW(33), .BW(33)) u_mr2 (
      .clock(clock),
      .a($signed({1'b0, max_range_ff})),
      .b($signed({1'b0, max_range_ff})),
      .p(mr2_p)
   );

   always_ff @(posedge clock) begin
      dsq10_ff  <= SW'(dd_p[0]) + SW'(dd_p[1]) + SW'(dd_p[2]);
      aa10_ff   <= SW'(aa_p[0]) + SW'(aa_p[1]) + SW'(aa_p[2]);
      bb10_ff   <= SW'(bb_p[0]) + SW'(bb_p[1]) + SW'(bb_p[2]);
      ad10_ff   <= SW'(ad_p[0]) + SW'(ad_p[1]) + SW'(ad_p[2]);
      bd10_ff   <= SW'(bd_p[0]) + SW'(bd_p[1]) + SW'(bd_p[2]);
      re2_10_ff <= re2_p;
      mr2_10_ff <= mr2_p;
   end

   // With a satellite first and a ground node second, the ground node is the
   // second one and its view vector is the negated difference. Otherwise the
   // first node's terms serve, which is also what the satellite pair needs.
   assign g_first = (satd_ff[SUM] == 2'b10);
   assign gsel    = g_first ? bb10_ff : aa10_ff;
   assign vsel    = g_first ? bd10_ff : ad10_ff;

   always_comb begin
      ctl_in.first_sat  = satd_ff[SUM][1];
      ctl_in.second_sat = satd_ff[SUM][0];
      ctl_in.range_ok   = dsq10_ff <= mr2_10_ff;
      ctl_in.ad_neg     = ad10_ff[SW-1];
      ctl_in.far_b      = (ad10_ff + dsq10_ff) <= 0;
      ctl_in.near_a     = aa10_ff >= re2_10_ff;
      ctl_in.near_b     = bb10_ff >= re2_10_ff;
      ctl_in.g_zero     = (gsel == '0);
      ctl_in.dsq_zero   = (dsq10_ff == '0);
      ctl_in.v_neg      = g_first ? (bd10_ff > 0) : ad10_ff[SW-1];
   end

   lvc_mul #(.AW(SW), .BW(SW)) u_x (.clock(clock), .a(gsel), .b(dsq10_ff), .p(x_p));
   lvc_mul #(.AW(SW), .BW(SW)) u_y (.clock(clock), .a(vsel), .b(vsel), .p(y_p));
   lvc_mul #(.AW(66), .BW(SW)) u_z (.clock(clock), .a(re2_10_ff), .b(dsq10_ff), .p(z_p));
   lvc_mul #(.AW(16), .BW(16)) u_ss (.clock(clock), .a(sin_min_ff), .b(sin_min_ff), .p(ss_p));
   lvc_mul #(.AW(32), .BW(2*SW)) u_t (.clock(clock), .a(ss_p), .b(x_p), .p(t_p));

   always_ff @(posedge clock) begin
      ctl_ff[0] <= ctl_in;
      for (int i = 1; i <= CTL_D; i++) begin
         ctl_ff[i] <= ctl_ff[i-1];
      end
      lhs_ff    <= x_p - y_p;
      z19_ff    <= z_p;
      far_ff[0] <= lhs_ff >= z19_ff;
      for (int i = 1; i <= FD; i++) begin
         far_ff[i] <= far_ff[i-1];
      end
      yd_ff[0] <= y_p;
      for (int i = 1; i <= YD; i++) begin
         yd_ff[i] <= yd_ff[i-1];
      end
      ok_ff[0] <= ok_in;
      for (int i = 1; i <= K; i++) begin
         ok_ff[i] <= ok_ff[i-1];
      end
   end

   // The projection is scaled by 2^15 before squaring, hence the 30-bit shift.
   always_comb begin
      c     = ctl_ff[CTL_D];
      l2    = $signed({yd_ff[YD], 30'b0});
      ok_in = 1'b0;
      case ({c.first_sat, c.second_sat})
         2'b11: begin
            ok_in = c.range_ok && (!c.ad_neg ? c.near_a
                                             : (c.far_b ? c.near_b : far_ff[FD]));
         end
         2'b00: begin
            ok_in = 1'b0;
         end
         default: begin
            if (c.g_zero) begin
               ok_in = 1'b0;
            end else if (c.dsq_zero) begin
               ok_in = sin_min_ff[15] || (sin_min_ff == '0);
            end else if (sin_min_ff == '0) begin
               ok_in = !c.v_neg;
            end else if (!sin_min_ff[15]) begin
               ok_in = !c.v_neg && (l2 >= t_p);
            end else begin
               ok_in = !c.v_neg || (l2 <= t_p);
            end
         end
      endcase
   end

   // Integer square root of the squared distance, one result bit per stage.
   always_ff @(posedge clock) begin
      sq_x_ff[0]   <= dsq10_ff[2*R-1:0];
      sq_rem_ff[0] <= '0;
      sq_q_ff[0]   <= '0;
   end

   for (genvar k = 1; k <= R; k++) begin : g_sqrt
      logic [R+1:0] rs;
      logic [R+1:0] trial;
      logic         take;
      assign rs    = {sq_rem_ff[k-1][R-1:0], sq_x_ff[k-1][2*R-1 -: 2]};
      assign trial = {sq_q_ff[k-1], 2'b01};
      assign take  = rs >= trial;
      always_ff @(posedge clock) begin
         sq_q_ff[k] <= {sq_q_ff[k-1][R-2:0], take};
      end
      if (k < R) begin : g_carry
         always_ff @(posedge clock) begin
            sq_rem_ff[k] <= take ? (rs - trial) : rs;
            sq_x_ff[k]   <= {sq_x_ff[k-1][2*R-3:0], 2'b00};
         end
      end
   end

   assign root_w   = (R+32)'(sq_q_ff[R]);
   assign dist_sat = (root_w > (R+32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : root_w[31:0];

   always_ff @(posedge clock) begin
      if (vld_ff[LAST-1]) begin
         rsp_ff.linked        <= ok_ff[K];
         rsp_ff.link_distance <= ok_ff[K] ? dist_sat : '0;
      end
   end

   assign rsp_strobe = vld_ff[LAST];
   assign rsp_data   = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(LAST+1) rsp_strobe)
      else $error("accepted request produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAST+1))
      else $error("response without a matching request");

   a_unlinked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.linked |-> rsp_data.link_distance == '0)
      else $error("distance reported for an unlinked pair");

   a_ground_pair: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEC-1] && !c.first_sat && !c.second_sat |=> !ok_ff[0])
      else $error("ground pair marked as linked");

   a_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEC-1] && c.first_sat && c.second_sat && !c.range_ok |=> !ok_ff[0])
      else $error("satellite pair linked beyond maximum range");

endmodule

`default_nettype wire
